FILE: rtl/core/vhv_pkg.sv
// Shared types, constants and the arctangent table of the heading and velocity unit.
package vhv_pkg;

   localparam int unsigned CoordWidthDefault   = 16;
   localparam int unsigned CordicStagesDefault = 16;
   localparam int unsigned FieldWidth          = 16;
   localparam int unsigned FieldExtWidth       = 24;
   localparam int unsigned VelWidth            = 24;
   localparam int unsigned TimeWidth           = 16;
   localparam int unsigned HeadingWidth        = 16;
   localparam int unsigned Preshift            = 32;
   localparam int unsigned AngleFrac           = 16;
   localparam int unsigned AngleWidth          = 32;
   localparam int unsigned AtanWidth           = 30;
   localparam int unsigned VelFrac             = 16;
   localparam int unsigned RemInitShift        = 8;
   localparam int unsigned DegUnits            = 128;
   localparam int unsigned AngleBits           = 14;

   localparam logic [AngleWidth-1:0]   ZMax       = AngleWidth'(90 * DegUnits) << AngleFrac;
   localparam logic [AngleWidth-1:0]   ZRound     = AngleWidth'(1) << (AngleFrac - 1);
   localparam logic [HeadingWidth-1:0] Heading90  = HeadingWidth'(90 * DegUnits);
   localparam logic [HeadingWidth-1:0] Heading270 = HeadingWidth'(270 * DegUnits);
   localparam logic [VelWidth-1:0]     VelPosMax  = VelWidth'(24'h7fffff);
   localparam logic [VelWidth-1:0]     VelNegMax  = VelWidth'(24'h800000);
   localparam logic [TimeWidth-1:0]    FlightTimeReset = TimeWidth'(256);

   typedef struct packed {
      logic signed [FieldWidth-1:0] src_x;
      logic signed [FieldWidth-1:0] src_y;
      logic signed [FieldWidth-1:0] dst_x;
      logic signed [FieldWidth-1:0] dst_y;
   } req_type;

   typedef struct packed {
      logic signed [VelWidth-1:0] vel_x;
      logic signed [VelWidth-1:0] vel_y;
      logic [HeadingWidth-1:0]    heading;
      logic                       zero_vector;
      logic                       vel_saturated;
   } rsp_type;

   typedef struct packed {
      logic dx_pos;
      logic dx_neg;
      logic dy_pos;
      logic dy_neg;
      logic zero;
      logic ovf_x;
      logic ovf_y;
   } side_type;

   function automatic logic [AtanWidth-1:0] atan_entry(input int unsigned idx);
      logic [AtanWidth-1:0] v;
      case (idx)
         0: v = AtanWidth'(377487360);
         1: v = AtanWidth'(222843801);
         2: v = AtanWidth'(117744544);
         3: v = AtanWidth'(59768969);
         4: v = AtanWidth'(30000467);
         5: v = AtanWidth'(15014858);
         6: v = AtanWidth'(7509261);
         7: v = AtanWidth'(3754860);
         8: v = AtanWidth'(1877459);
         9: v = AtanWidth'(938733);
         10: v = AtanWidth'(469367);
         11: v = AtanWidth'(234683);
         12: v = AtanWidth'(117342);
         13: v = AtanWidth'(58671);
         14: v = AtanWidth'(29335);
         15: v = AtanWidth'(14668);
         16: v = AtanWidth'(7334);
         17: v = AtanWidth'(3667);
         18: v = AtanWidth'(1833);
         19: v = AtanWidth'(917);
         20: v = AtanWidth'(458);
         21: v = AtanWidth'(229);
         22: v = AtanWidth'(115);
         23: v = AtanWidth'(57);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/vhv_stage.sv
// One stage: a quotient bit per velocity divider; the first CORDIC_STAGES also rotate.
module vhv_stage #(
   parameter int unsigned COORD_WIDTH   = 16,
   parameter int unsigned CORDIC_STAGES = 16,
   parameter int unsigned STAGE         = 0
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      advance,
   input  logic [vhv_pkg::TimeWidth-1:0]             divisor,
   input  logic                                      valid_i,
   input  vhv_pkg::side_type                         side_i,
   input  logic [COORD_WIDTH:0]                      mag_x_i,
   input  logic [COORD_WIDTH:0]                      mag_y_i,
   input  logic [COORD_WIDTH+vhv_pkg::Preshift+2:0]  x_i,
   input  logic [COORD_WIDTH+vhv_pkg::Preshift+2:0]  y_i,
   input  logic [vhv_pkg::AngleWidth-1:0]            z_i,
   input  logic [vhv_pkg::TimeWidth-1:0]             rem_x_i,
   input  logic [vhv_pkg::TimeWidth-1:0]             rem_y_i,
   input  logic [vhv_pkg::VelWidth-1:0]              q_x_i,
   input  logic [vhv_pkg::VelWidth-1:0]              q_y_i,
   output logic                                      valid_o,
   output vhv_pkg::side_type                         side_o,
   output logic [COORD_WIDTH:0]                      mag_x_o,
   output logic [COORD_WIDTH:0]                      mag_y_o,
   output logic [COORD_WIDTH+vhv_pkg::Preshift+2:0]  x_o,
   output logic [COORD_WIDTH+vhv_pkg::Preshift+2:0]  y_o,
   output logic [vhv_pkg::AngleWidth-1:0]            z_o,
   output logic [vhv_pkg::TimeWidth-1:0]             rem_x_o,
   output logic [vhv_pkg::TimeWidth-1:0]             rem_y_o,
   output logic [vhv_pkg::VelWidth-1:0]              q_x_o,
   output logic [vhv_pkg::VelWidth-1:0]              q_y_o
);
   import vhv_pkg::*;

   localparam int unsigned MW  = COORD_WIDTH + 1;
   localparam int unsigned CW  = COORD_WIDTH + Preshift + 3;
   localparam int unsigned BIT = VelWidth - 1 - STAGE;

   logic                    valid_ff;
   side_type                side_ff;
   logic [MW-1:0]           mag_x_ff, mag_y_ff;
   logic [CW-1:0]           x_ff, y_ff, x_in, y_in;
   logic [AngleWidth-1:0]   z_ff, z_in;
   logic [TimeWidth-1:0]    rem_x_ff, rem_y_ff, rem_x_in, rem_y_in;
   logic [VelWidth-1:0]     q_x_ff, q_y_ff, q_x_in, q_y_in;
   logic                    dbit_x, dbit_y;
   logic [TimeWidth:0]      trial_x, trial_y;

   generate
      if (BIT >= VelFrac && (BIT - VelFrac) < MW) begin : g_dbit
         assign dbit_x = mag_x_i[BIT-VelFrac];
         assign dbit_y = mag_y_i[BIT-VelFrac];
      end else begin : g_nobit
         assign dbit_x = 1'b0;
         assign dbit_y = 1'b0;
      end
   endgenerate

   generate
      if (STAGE < CORDIC_STAGES) begin : g_rot
         logic [CW-1:0] xs, ys;
         assign xs = CW'($signed(x_i) >>> STAGE);
         assign ys = CW'($signed(y_i) >>> STAGE);
         always_comb begin
            if (!y_i[CW-1]) begin
               x_in = x_i + ys;
               y_in = y_i - xs;
               z_in = z_i + AngleWidth'(atan_entry(STAGE));
            end else begin
               x_in = x_i - ys;
               y_in = y_i + xs;
               z_in = z_i - AngleWidth'(atan_entry(STAGE));
            end
         end
      end else begin : g_hold
         assign x_in = x_i;
         assign y_in = y_i;
         assign z_in = z_i;
      end
   endgenerate

   assign trial_x = {rem_x_i, dbit_x};
   assign trial_y = {rem_y_i, dbit_y};

   always_comb begin
      q_x_in = q_x_i;
      q_y_in = q_y_i;
      if (trial_x >= {1'b0, divisor}) begin
         rem_x_in    = TimeWidth'(trial_x - {1'b0, divisor});
         q_x_in[BIT] = 1'b1;
      end else begin
         rem_x_in = TimeWidth'(trial_x);
      end
      if (trial_y >= {1'b0, divisor}) begin
         rem_y_in    = TimeWidth'(trial_y - {1'b0, divisor});
         q_y_in[BIT] = 1'b1;
      end else begin
         rem_y_in = TimeWidth'(trial_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff  <= side_i;
         mag_x_ff <= mag_x_i;
         mag_y_ff <= mag_y_i;
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         q_x_ff   <= q_x_in;
         q_y_ff   <= q_y_in;
      end
   end

   assign valid_o = valid_ff;
   assign side_o  = side_ff;
   assign mag_x_o = mag_x_ff;
   assign mag_y_o = mag_y_ff;
   assign x_o     = x_ff;
   assign y_o     = y_ff;
   assign z_o     = z_ff;
   assign rem_x_o = rem_x_ff;
   assign rem_y_o = rem_y_ff;
   assign q_x_o   = q_x_ff;
   assign q_y_o   = q_y_ff;

endmodule

FILE: rtl/core/vector_heading_and_velocity_unit.sv
// Top level of the heading and velocity unit: input stage, stage chain and result register.
// A request enters every cycle unless the result side stalls; each result passes through
// one difference stage, 24 stages that each carry one quotient bit of both velocity
// dividers (the first CORDIC_STAGES also carry one rotation) and one result stage. The
// 24-bit velocity quotient sets the depth. flight_time must be written only while
// no request is in flight; a value of zero is treated as one.
module vector_heading_and_velocity_unit #(
   parameter int unsigned COORD_WIDTH   = vhv_pkg::CoordWidthDefault,
   parameter int unsigned CORDIC_STAGES = vhv_pkg::CordicStagesDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  vhv_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output vhv_pkg::rsp_type               rsp_data,
   input  logic                           csr_write,
   input  logic [vhv_pkg::TimeWidth-1:0]  csr_wdata
);
   import vhv_pkg::*;

   localparam int unsigned MW     = COORD_WIDTH + 1;
   localparam int unsigned CW     = COORD_WIDTH + Preshift + 3;
   localparam int unsigned NSTAGE = VelWidth;
   localparam int unsigned OW     = (MW > VelWidth ? MW : VelWidth) + 1;

   logic [TimeWidth-1:0]  flight_time_ff;
   logic [TimeWidth-1:0]  divisor;
   logic                  advance;

   logic [FieldExtWidth-1:0] sx_w, sy_w, dx_w, dy_w;
   logic signed [MW-1:0]     diff_x, diff_y;
   logic [MW-1:0]            mag_x_in, mag_y_in;
   side_type                 side_in;

   logic                  valid_c [0:NSTAGE];
   side_type              side_c  [0:NSTAGE];
   logic [MW-1:0]         mag_x_c [0:NSTAGE];
   logic [MW-1:0]         mag_y_c [0:NSTAGE];
   logic [CW-1:0]         x_c     [0:NSTAGE];
   logic [CW-1:0]         y_c     [0:NSTAGE];
   logic [AngleWidth-1:0] z_c     [0:NSTAGE];
   logic [TimeWidth-1:0]  rem_x_c [0:NSTAGE];
   logic [TimeWidth-1:0]  rem_y_c [0:NSTAGE];
   logic [VelWidth-1:0]   q_x_c   [0:NSTAGE];
   logic [VelWidth-1:0]   q_y_c   [0:NSTAGE];

   logic                  valid0_ff;
   side_type              side0_ff;
   logic [MW-1:0]         mag_x0_ff, mag_y0_ff;

   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff, rsp_data_in;
   side_type              side_end;
   logic [AngleWidth-1:0] z_end, z_clamp, z_rnd;
   logic [HeadingWidth-1:0] angle;
   logic                  sat_x, sat_y;
   logic [VelWidth-1:0]   vel_x_w, vel_y_w;

   assign divisor   = (flight_time_ff == '0) ? TimeWidth'(1) : flight_time_ff;
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_time_ff <= FlightTimeReset;
      end else if (csr_write) begin
         flight_time_ff <= csr_wdata;
      end
   end

   assign sx_w = FieldExtWidth'(req_data.src_x);
   assign sy_w = FieldExtWidth'(req_data.src_y);
   assign dx_w = FieldExtWidth'(req_data.dst_x);
   assign dy_w = FieldExtWidth'(req_data.dst_y);

   always_comb begin
      diff_x = $signed({dx_w[COORD_WIDTH-1], dx_w[COORD_WIDTH-1:0]})
             - $signed({sx_w[COORD_WIDTH-1], sx_w[COORD_WIDTH-1:0]});
      diff_y = $signed({dy_w[COORD_WIDTH-1], dy_w[COORD_WIDTH-1:0]})
             - $signed({sy_w[COORD_WIDTH-1], sy_w[COORD_WIDTH-1:0]});
      mag_x_in = diff_x[MW-1] ? MW'(-diff_x) : MW'(diff_x);
      mag_y_in = diff_y[MW-1] ? MW'(-diff_y) : MW'(diff_y);
      side_in.dx_neg = diff_x[MW-1];
      side_in.dy_neg = diff_y[MW-1];
      side_in.dx_pos = !diff_x[MW-1] && (diff_x != '0);
      side_in.dy_pos = !diff_y[MW-1] && (diff_y != '0);
      side_in.zero   = (diff_x == '0) && (diff_y == '0);
      side_in.ovf_x  = OW'(mag_x_in) >= OW'({divisor, {RemInitShift{1'b0}}});
      side_in.ovf_y  = OW'(mag_y_in) >= OW'({divisor, {RemInitShift{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (advance) begin
         valid0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side0_ff  <= side_in;
         mag_x0_ff <= mag_x_in;
         mag_y0_ff <= mag_y_in;
      end
   end

   assign valid_c[0] = valid0_ff;
   assign side_c[0]  = side0_ff;
   assign mag_x_c[0] = mag_x0_ff;
   assign mag_y_c[0] = mag_y0_ff;
   assign x_c[0]     = CW'({mag_x0_ff, {Preshift{1'b0}}});
   assign y_c[0]     = CW'({mag_y0_ff, {Preshift{1'b0}}});
   assign z_c[0]     = '0;
   assign rem_x_c[0] = TimeWidth'(mag_x0_ff >> RemInitShift);
   assign rem_y_c[0] = TimeWidth'(mag_y0_ff >> RemInitShift);
   assign q_x_c[0]   = '0;
   assign q_y_c[0]   = '0;

   generate
      for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
         vhv_stage #(
            .COORD_WIDTH  (COORD_WIDTH),
            .CORDIC_STAGES(CORDIC_STAGES),
            .STAGE        (k)
         ) u_stage (
            .clock  (clock),
            .reset  (reset),
            .advance(advance),
            .divisor(divisor),
            .valid_i(valid_c[k]),
            .side_i (side_c[k]),
            .mag_x_i(mag_x_c[k]),
            .mag_y_i(mag_y_c[k]),
            .x_i    (x_c[k]),
            .y_i    (y_c[k]),
            .z_i    (z_c[k]),
            .rem_x_i(rem_x_c[k]),
            .rem_y_i(rem_y_c[k]),
            .q_x_i  (q_x_c[k]),
            .q_y_i  (q_y_c[k]),
            .valid_o(valid_c[k+1]),
            .side_o (side_c[k+1]),
            .mag_x_o(mag_x_c[k+1]),
            .mag_y_o(mag_y_c[k+1]),
            .x_o    (x_c[k+1]),
            .y_o    (y_c[k+1]),
            .z_o    (z_c[k+1]),
            .rem_x_o(rem_x_c[k+1]),
            .rem_y_o(rem_y_c[k+1]),
            .q_x_o  (q_x_c[k+1]),
            .q_y_o  (q_y_c[k+1])
         );
      end
   endgenerate

   assign side_end = side_c[NSTAGE];
   assign z_end    = z_c[NSTAGE];

   always_comb begin
      if (z_end[AngleWidth-1]) begin
         z_clamp = '0;
      end else if (z_end > ZMax) begin
         z_clamp = ZMax;
      end else begin
         z_clamp = z_end;
      end
      z_rnd = z_clamp + ZRound;
      angle = HeadingWidth'(z_rnd[AngleFrac+AngleBits-1:AngleFrac]);

      if (side_end.dx_neg) begin
         sat_x   = side_end.ovf_x || (q_x_c[NSTAGE] > VelNegMax);
         vel_x_w = VelWidth'(-(sat_x ? VelNegMax : q_x_c[NSTAGE]));
      end else begin
         sat_x   = side_end.ovf_x || q_x_c[NSTAGE][VelWidth-1];
         vel_x_w = sat_x ? VelPosMax : q_x_c[NSTAGE];
      end
      if (side_end.dy_neg) begin
         sat_y   = side_end.ovf_y || (q_y_c[NSTAGE] > VelNegMax);
         vel_y_w = VelWidth'(-(sat_y ? VelNegMax : q_y_c[NSTAGE]));
      end else begin
         sat_y   = side_end.ovf_y || q_y_c[NSTAGE][VelWidth-1];
         vel_y_w = sat_y ? VelPosMax : q_y_c[NSTAGE];
      end

      rsp_data_in = '0;
      if (side_end.zero) begin
         rsp_data_in.zero_vector = 1'b1;
      end else begin
         rsp_data_in.vel_x         = vel_x_w;
         rsp_data_in.vel_y         = vel_y_w;
         rsp_data_in.vel_saturated = sat_x || sat_y;
         if (side_end.dy_pos) begin
            rsp_data_in.heading = side_end.dx_pos ? Heading90 + angle : Heading270 - angle;
         end else begin
            rsp_data_in.heading = side_end.dx_pos ? Heading90 - angle : Heading270 + angle;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_c[NSTAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.heading <= HeadingWidth'(360 * DegUnits))
      else $error("heading out of range");

   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_vector |->
         rsp_data.vel_x == '0 && rsp_data.vel_y == '0 &&
         rsp_data.heading == '0 && !rsp_data.vel_saturated)
      else $error("zero vector result not cleared");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(valid_c[NSTAGE]))
      else $error("pipeline moved while stalled");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench of the heading and velocity unit: scoreboard, drivers and phases.
`timescale 1ns / 100ps

module tb;
   import vhv_pkg::*;

   localparam int unsigned Latency   = 26;
   localparam int unsigned CycleCap  = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic [TimeWidth-1:0] csr_wdata = '0;

   int unsigned cycle_count = 0;
   int unsigned fail_count  = 0;
   bit          hold_off    = 1'b0;
   bit          calm        = 1'b0;
   bit          draining    = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   vector_heading_and_velocity_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   class heading_scoreboard;
      rsp_type pending[$];
      logic [15:0] flight_time = FlightTimeReset;

      function automatic logic [23:0] velocity(input longint d, input logic [15:0] t,
                                               inout bit sat);
         longint unsigned mag, q;
         mag = (d < 0) ? -d : d;
         q = (mag << 16) / t;
         if (d < 0) begin
            if (q > 64'd8388608) begin
               q = 64'd8388608;
               sat = 1'b1;
            end
            return 24'(-q);
         end
         if (q > 64'd8388607) begin
            q = 64'd8388607;
            sat = 1'b1;
         end
         return 24'(q);
      endfunction

      function automatic longint unsigned angle(input longint unsigned ax,
                                                input longint unsigned ay);
         longint x, y, z, xs, ys;
         x = longint'(ax << Preshift);
         y = longint'(ay << Preshift);
         z = 0;
         for (int i = 0; i < CordicStagesDefault; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + longint'(atan_entry(i));
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - longint'(atan_entry(i));
            end
         end
         if (z < 0) z = 0;
         if (z > longint'(ZMax)) z = longint'(ZMax);
         return (z + 32768) >> AngleFrac;
      endfunction

      function void note_request(input req_type r);
         rsp_type e;
         longint dx, dy;
         logic [15:0] t;
         bit sat;
         longint unsigned a;
         dx = longint'(r.dst_x) - longint'(r.src_x);
         dy = longint'(r.dst_y) - longint'(r.src_y);
         t = (flight_time == 0) ? 16'd1 : flight_time;
         sat = 1'b0;
         e = '0;
         if (dx == 0 && dy == 0) begin
            e.zero_vector = 1'b1;
         end else begin
            e.vel_x = velocity(dx, t, sat);
            e.vel_y = velocity(dy, t, sat);
            a = angle(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
            if (dy > 0)
               e.heading = (dx > 0) ? Heading90 + 16'(a) : Heading270 - 16'(a);
            else
               e.heading = (dx > 0) ? Heading90 - 16'(a) : Heading270 + 16'(a);
            e.vel_saturated = sat;
         end
         pending.push_back(e);
      endfunction

      function int check_response(input rsp_type g);
         rsp_type e;
         int errs;
         errs = 0;
         if (pending.size() == 0) begin
            $error("unexpected response %h", g);
            return 1;
         end
         e = pending.pop_front();
         if (g.vel_x !== e.vel_x) begin
            $error("vel_x expected %h actual %h", e.vel_x, g.vel_x);
            errs++;
         end
         if (g.vel_y !== e.vel_y) begin
            $error("vel_y expected %h actual %h", e.vel_y, g.vel_y);
            errs++;
         end
         if (g.heading !== e.heading) begin
            $error("heading expected %0d actual %0d", e.heading, g.heading);
            errs++;
         end
         if (g.zero_vector !== e.zero_vector) begin
            $error("zero_vector expected %b actual %b", e.zero_vector, g.zero_vector);
            errs++;
         end
         if (g.vel_saturated !== e.vel_saturated) begin
            $error("vel_saturated expected %b actual %b", e.vel_saturated,
                   g.vel_saturated);
            errs++;
         end
         return errs;
      endfunction
   endclass

   heading_scoreboard board = new();

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleCap) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // check responses and drive the response stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         fail_count <= fail_count + board.check_response(rsp_data);
      if (hold_off)
         rsp_stall <= 1'b1;
      else if (calm || draining)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < 19);
   end

   task automatic send_request(input req_type r);
      while (!calm && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
   endtask

   task automatic stop_requests();
      req_valid <= 1'b0;
   endtask

   task automatic send_points(input int sx, input int sy, input int ex, input int ey);
      req_type r;
      r.src_x = 16'(sx);
      r.src_y = 16'(sy);
      r.dst_x = 16'(ex);
      r.dst_y = 16'(ey);
      send_request(r);
   endtask

   task automatic wait_idle();
      stop_requests();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   task automatic set_flight_time(input logic [15:0] t);
      csr_write <= 1'b1;
      csr_wdata <= t;
      @(posedge clock);
      csr_write <= 1'b0;
      board.flight_time = t;
   endtask

   function automatic req_type random_request();
      req_type r;
      int unsigned m;
      r = req_type'({$urandom, $urandom});
      m = $urandom_range(9);
      if (m < 3) begin
         r.dst_x = r.src_x + 16'($urandom_range(255) - 128);
         r.dst_y = r.src_y + 16'($urandom_range(255) - 128);
      end else if (m == 3) begin
         r.dst_x = r.src_x;
      end else if (m == 4) begin
         r.dst_y = r.src_y;
      end else if (m == 5) begin
         r.dst_x = r.src_x;
         r.dst_y = r.src_y;
      end
      return r;
   endfunction

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) send_request(random_request());
      stop_requests();
   endtask

   initial begin
      logic [15:0] times[6];
      times = '{16'd1, 16'd65535, 16'd0, 16'd256, 16'd37, 16'd4000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      draining = 1'b0;

      // directed: axes, diagonals, extremes, zero vector
      send_points(0, 0, 0, 0);
      send_points(5, 5, 5, 4);
      send_points(5, 5, 5, 6);
      send_points(5, 5, 6, 5);
      send_points(5, 5, 4, 5);
      send_points(0, 0, 3, 3);
      send_points(0, 0, -3, 3);
      send_points(0, 0, 3, -3);
      send_points(0, 0, -3, -3);
      send_points(-32768, -32768, 32767, 32767);
      send_points(32767, 32767, -32768, -32768);
      send_points(-32768, 32767, 32767, -32768);
      send_points(0, 0, 1, 1000);
      send_points(0, 0, 1000, -1);
      send_points(100, -200, 100, -200);
      wait_idle();

      // receiver holds off while requests keep coming
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         random_phase(60);
      join
      wait_idle();

      foreach (times[k]) begin
         set_flight_time(times[k]);
         calm = (k == 3);
         random_phase(70);
         wait_idle();
      end
      calm = 1'b0;
      draining = 1'b1;
      wait_idle();
      if (fail_count == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
